FILE: design/pidt1obs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID-T1 controller with observer: shared package
// Widths, reset values, register indexes and the microcode control word.
// ----------------------------------------------------------------------------
package pidt1obs_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned A_W       = DW + 4;
  localparam int unsigned ACC_W     = A_W + DW;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned NUM_STEPS = 13;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

  localparam logic signed [DW-1:0] PERIOD_Q =
      DW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic signed [DW-1:0] RST_SETPOINT       = 32'sd9175;
  localparam logic signed [DW-1:0] RST_COEF_ERR_NOW   = 32'sd2209571;
  localparam logic signed [DW-1:0] RST_COEF_ERR_PREV  = -32'sd4362638;
  localparam logic signed [DW-1:0] RST_COEF_ERR_PREV2 = 32'sd2153325;
  localparam logic signed [DW-1:0] RST_COEF_OUT_PREV  = 32'sd112347;
  localparam logic signed [DW-1:0] RST_COEF_OUT_PREV2 = -32'sd46811;
  localparam logic [DW-2:0]        RST_DRIVE_LIMIT    = 31'd117965;
  localparam logic [DW-2:0]        RST_ESTIMATE_LIMIT = 31'd20119;

  localparam logic [IDX_W-1:0] REG_SETPOINT       = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_ERR_NOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_ERR_PREV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_ERR_PREV2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_OUT_PREV  = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_OUT_PREV2 = 3'd5;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;
  localparam logic [IDX_W-1:0] REG_ESTIMATE_LIMIT = 3'd7;

  typedef enum logic [2:0] {
    OPA_OBS_VEL = 3'd0,
    OPA_OBS_POS = 3'd1,
    OPA_ERR     = 3'd2,
    OPA_ERR1    = 3'd3,
    OPA_ERR2    = 3'd4,
    OPA_RAW1    = 3'd5,
    OPA_RAW2    = 3'd6
  } opa_e;

  typedef enum logic [2:0] {
    OPB_PERIOD = 3'd0,
    OPB_C0     = 3'd1,
    OPB_C1     = 3'd2,
    OPB_C2     = 3'd3,
    OPB_D1     = 3'd4,
    OPB_D2     = 3'd5
  } opb_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_e;

  typedef enum logic [2:0] {
    WB_NONE  = 3'd0,
    WB_LATCH = 3'd1,
    WB_VEL   = 3'd2,
    WB_POS   = 3'd3,
    WB_RAW   = 3'd4
  } wb_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_WAIT_OUT = 2'd2,
    JMP_HOME     = 2'd3
  } jmp_e;

  typedef struct packed {
    opa_e opa;
    opb_e opb;
    acc_e acc;
    wb_e  wb;
    jmp_e jmp;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_status_t;

endpackage
`default_nettype wire

FILE: design/pidt1obs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID-T1 controller with observer: microcode sequencer
// Step counter over a read-only program; each step issues one control word.
// ----------------------------------------------------------------------------
module pidt1obs_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pidt1obs_pkg::seq_status_t status_i,
  output pidt1obs_pkg::ctrl_t       ctrl_o
);

  logic [pidt1obs_pkg::STEP_W-1:0] step_q, step_d;
  pidt1obs_pkg::ctrl_t word;

  function automatic pidt1obs_pkg::ctrl_t ucode(input logic [pidt1obs_pkg::STEP_W-1:0] s);
    pidt1obs_pkg::ctrl_t w;
    w.opa = pidt1obs_pkg::OPA_ERR;
    w.opb = pidt1obs_pkg::OPB_C0;
    w.acc = pidt1obs_pkg::ACC_HOLD;
    w.wb  = pidt1obs_pkg::WB_NONE;
    w.jmp = pidt1obs_pkg::JMP_NEXT;
    unique case (s)
      4'd0: begin
        w.wb  = pidt1obs_pkg::WB_LATCH;
        w.jmp = pidt1obs_pkg::JMP_WAIT_IN;
      end
      4'd1: begin
        w.opa = pidt1obs_pkg::OPA_OBS_VEL;
        w.opb = pidt1obs_pkg::OPB_PERIOD;
      end
      4'd2: w.acc = pidt1obs_pkg::ACC_LOAD;
      4'd3: w.wb = pidt1obs_pkg::WB_VEL;
      4'd4: begin
        w.opa = pidt1obs_pkg::OPA_OBS_POS;
        w.opb = pidt1obs_pkg::OPB_PERIOD;
      end
      4'd5: w.acc = pidt1obs_pkg::ACC_LOAD;
      4'd6: begin
        w.wb  = pidt1obs_pkg::WB_POS;
        w.opa = pidt1obs_pkg::OPA_ERR;
        w.opb = pidt1obs_pkg::OPB_C0;
      end
      4'd7: begin
        w.acc = pidt1obs_pkg::ACC_LOAD;
        w.opa = pidt1obs_pkg::OPA_ERR1;
        w.opb = pidt1obs_pkg::OPB_C1;
      end
      4'd8: begin
        w.acc = pidt1obs_pkg::ACC_ADD;
        w.opa = pidt1obs_pkg::OPA_ERR2;
        w.opb = pidt1obs_pkg::OPB_C2;
      end
      4'd9: begin
        w.acc = pidt1obs_pkg::ACC_ADD;
        w.opa = pidt1obs_pkg::OPA_RAW1;
        w.opb = pidt1obs_pkg::OPB_D1;
      end
      4'd10: begin
        w.acc = pidt1obs_pkg::ACC_ADD;
        w.opa = pidt1obs_pkg::OPA_RAW2;
        w.opb = pidt1obs_pkg::OPB_D2;
      end
      4'd11: w.acc = pidt1obs_pkg::ACC_ADD;
      4'd12: begin
        w.wb  = pidt1obs_pkg::WB_RAW;
        w.jmp = pidt1obs_pkg::JMP_WAIT_OUT;
      end
      default: w.jmp = pidt1obs_pkg::JMP_HOME;
    endcase
    return w;
  endfunction

  assign word   = ucode(step_q);
  assign ctrl_o = word;

  always_comb begin
    step_d = step_q + 1'b1;
    unique case (word.jmp)
      pidt1obs_pkg::JMP_NEXT: step_d = step_q + 1'b1;
      pidt1obs_pkg::JMP_WAIT_IN: begin
        if (!status_i.in_valid) step_d = step_q;
      end
      pidt1obs_pkg::JMP_WAIT_OUT: begin
        step_d = status_i.out_free ? '0 : step_q;
      end
      pidt1obs_pkg::JMP_HOME: step_d = '0;
      default: step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/pid_t1_controller_with_observer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID-T1 controller with observer: top level
// The microcode program runs all seven products through one shared registered
// multiplier; a new sample is taken only after the previous result has been
// written to the output registers.
// Reset: control and filter state clear, registers load their defaults.
// ----------------------------------------------------------------------------
module pid_t1_controller_with_observer_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [pidt1obs_pkg::DW-1:0]   measured_position_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [pidt1obs_pkg::DW-1:0]        drive_o,
  output logic                                      drive_clamped_o,
  output logic [pidt1obs_pkg::DW-2:0]               estimated_position_o,
  output logic signed [pidt1obs_pkg::DW-1:0]        estimated_velocity_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pidt1obs_pkg::IDX_W-1:0]       cfg_index_i,
  input  wire logic [pidt1obs_pkg::DW-1:0]          cfg_data_i
);

  localparam int unsigned DW    = pidt1obs_pkg::DW;
  localparam int unsigned A_W   = pidt1obs_pkg::A_W;
  localparam int unsigned ACC_W = pidt1obs_pkg::ACC_W;
  localparam int unsigned FB    = pidt1obs_pkg::FRAC_BITS;

  localparam logic signed [DW-1:0]    DW_MAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]    DW_MIN   = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FB - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_wide(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v[DW] != v[DW-1]) r = v[DW] ? DW_MIN : DW_MAX;
    else r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] finish(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [DW-1:0]    r;
    s = (a + ACC_HALF) >>> FB;
    if (s > ACC_MAX) r = DW_MAX;
    else if (s < ACC_MIN) r = DW_MIN;
    else r = s[DW-1:0];
    return r;
  endfunction

  pidt1obs_pkg::ctrl_t       ctrl;
  pidt1obs_pkg::seq_status_t status;

  logic in_accept, out_free, emit;

  logic signed [DW-1:0] setpoint_q, c0_q, c1_q, c2_q, d1_q, d2_q;
  logic [DW-2:0]        dlimit_q, elimit_q;

  logic signed [DW-1:0] err1_q, err2_q, raw1_q, raw2_q, clamp_q, vel_q;
  logic [DW-2:0]        pos_q;

  logic signed [DW-1:0] err_q;
  logic signed [DW:0]   innov_q;
  logic signed [ACC_W-1:0] prod_q, acc_q;

  logic out_valid_q, hit_q;
  logic signed [DW-1:0] drive_q, evel_q;
  logic [DW-2:0]        epos_q;

  logic signed [A_W-1:0]   innov_x, innov3, op_a;
  logic signed [DW-1:0]    op_b, fin, raw, drv, dl;
  logic signed [DW:0]      err_wide, innov_d, vel_sum, pos_sum;
  logic signed [DW-1:0]    pos_sat;
  logic [DW-2:0]           pos_new;
  logic                    hit;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (ctrl.jmp != pidt1obs_pkg::JMP_WAIT_IN);
  assign in_accept = in_valid_i && !in_stall_o;
  assign emit      = (ctrl.wb == pidt1obs_pkg::WB_RAW) && out_free;

  assign status.in_valid = in_valid_i;
  assign status.out_free = out_free;

  pidt1obs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= pidt1obs_pkg::RST_SETPOINT;
      c0_q       <= pidt1obs_pkg::RST_COEF_ERR_NOW;
      c1_q       <= pidt1obs_pkg::RST_COEF_ERR_PREV;
      c2_q       <= pidt1obs_pkg::RST_COEF_ERR_PREV2;
      d1_q       <= pidt1obs_pkg::RST_COEF_OUT_PREV;
      d2_q       <= pidt1obs_pkg::RST_COEF_OUT_PREV2;
      dlimit_q   <= pidt1obs_pkg::RST_DRIVE_LIMIT;
      elimit_q   <= pidt1obs_pkg::RST_ESTIMATE_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pidt1obs_pkg::REG_SETPOINT:       setpoint_q <= cfg_data_i;
        pidt1obs_pkg::REG_COEF_ERR_NOW:   c0_q       <= cfg_data_i;
        pidt1obs_pkg::REG_COEF_ERR_PREV:  c1_q       <= cfg_data_i;
        pidt1obs_pkg::REG_COEF_ERR_PREV2: c2_q       <= cfg_data_i;
        pidt1obs_pkg::REG_COEF_OUT_PREV:  d1_q       <= cfg_data_i;
        pidt1obs_pkg::REG_COEF_OUT_PREV2: d2_q       <= cfg_data_i;
        pidt1obs_pkg::REG_DRIVE_LIMIT:    dlimit_q   <= cfg_data_i[DW-2:0];
        pidt1obs_pkg::REG_ESTIMATE_LIMIT: elimit_q   <= cfg_data_i[DW-2:0];
      endcase
    end
  end

  // Observer operands carry the innovation three times over.
  assign innov_x = {{(A_W-DW-1){innov_q[DW]}}, innov_q};
  assign innov3  = (innov_x <<< 1) + innov_x;

  always_comb begin
    unique case (ctrl.opa)
      pidt1obs_pkg::OPA_OBS_VEL: op_a = {{(A_W-DW){clamp_q[DW-1]}}, clamp_q} + innov3;
      pidt1obs_pkg::OPA_OBS_POS: op_a = {{(A_W-DW){vel_q[DW-1]}}, vel_q} + innov3;
      pidt1obs_pkg::OPA_ERR:     op_a = {{(A_W-DW){err_q[DW-1]}}, err_q};
      pidt1obs_pkg::OPA_ERR1:    op_a = {{(A_W-DW){err1_q[DW-1]}}, err1_q};
      pidt1obs_pkg::OPA_ERR2:    op_a = {{(A_W-DW){err2_q[DW-1]}}, err2_q};
      pidt1obs_pkg::OPA_RAW1:    op_a = {{(A_W-DW){raw1_q[DW-1]}}, raw1_q};
      pidt1obs_pkg::OPA_RAW2:    op_a = {{(A_W-DW){raw2_q[DW-1]}}, raw2_q};
      default:                   op_a = '0;
    endcase
    unique case (ctrl.opb)
      pidt1obs_pkg::OPB_PERIOD: op_b = pidt1obs_pkg::PERIOD_Q;
      pidt1obs_pkg::OPB_C0:     op_b = c0_q;
      pidt1obs_pkg::OPB_C1:     op_b = c1_q;
      pidt1obs_pkg::OPB_C2:     op_b = c2_q;
      pidt1obs_pkg::OPB_D1:     op_b = d1_q;
      pidt1obs_pkg::OPB_D2:     op_b = d2_q;
      default:                  op_b = '0;
    endcase
  end

  always_comb begin
    err_wide = {setpoint_q[DW-1], setpoint_q} - {measured_position_i[DW-1], measured_position_i};
    innov_d  = {measured_position_i[DW-1], measured_position_i} - {2'b00, pos_q};
    fin      = finish(acc_q);
    vel_sum  = {vel_q[DW-1], vel_q} + {fin[DW-1], fin};
    pos_sum  = {2'b00, pos_q} + {fin[DW-1], fin};
    pos_sat  = sat_wide(pos_sum);
    if (pos_sat > $signed({1'b0, elimit_q})) pos_new = elimit_q;
    else if (pos_sat < 0) pos_new = '0;
    else pos_new = pos_sat[DW-2:0];
    raw = fin;
    dl  = $signed({1'b0, dlimit_q});
    hit = 1'b0;
    drv = raw;
    if (raw > dl) begin
      drv = dl;
      hit = 1'b1;
    end else if (raw < -dl) begin
      drv = -dl;
      hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    unique case (ctrl.acc)
      pidt1obs_pkg::ACC_HOLD: acc_q <= acc_q;
      pidt1obs_pkg::ACC_LOAD: acc_q <= prod_q;
      pidt1obs_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default:                acc_q <= acc_q;
    endcase
    if (in_accept) begin
      err_q   <= sat_wide(err_wide);
      innov_q <= innov_d;
    end
    if (emit) begin
      drive_q <= drv;
      hit_q   <= hit;
      epos_q  <= pos_q;
      evel_q  <= vel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err1_q      <= '0;
      err2_q      <= '0;
      raw1_q      <= '0;
      raw2_q      <= '0;
      clamp_q     <= '0;
      vel_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.wb == pidt1obs_pkg::WB_VEL) vel_q <= sat_wide(vel_sum);
      if (ctrl.wb == pidt1obs_pkg::WB_POS) pos_q <= pos_new;
      if (emit) begin
        err2_q  <= err1_q;
        err1_q  <= err_q;
        raw2_q  <= raw1_q;
        raw1_q  <= raw;
        clamp_q <= drv;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign drive_o              = drive_q;
  assign drive_clamped_o      = hit_q;
  assign estimated_position_o = epos_q;
  assign estimated_velocity_o = evel_q;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID-T1 controller with observer: self-checking testbench
// A clocked driver sends position samples from a queue and a clocked monitor
// takes results. Both sides pause at random but for the burst phase. Each
// sample transfer runs a fixed-point model of the observer and controller,
// and the expected output is queued. Every output transfer is compared
// field by field with the oldest expected output. The register settings
// change between phases, once all outputs of the previous phase have arrived.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DW = pidt1obs_pkg::DW;
  localparam int IDX_W = pidt1obs_pkg::IDX_W;
  localparam int FRAC_BITS = pidt1obs_pkg::FRAC_BITS;
  localparam int WIDE_W = 96;
  localparam int NUM_REGS = 2 ** IDX_W;
  localparam int QUIET_LIMIT = 4000;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 clamped;
    logic [DW-2:0]        position;
    logic signed [DW-1:0] velocity;
  } pid_out_t;

  typedef enum int {PLAN_DEFAULT, PLAN_TUNED, PLAN_WILD, PLAN_CORNER} plan_e;

  localparam wide_t WORD_MAX = (wide_t'(1) <<< (DW - 1)) - wide_t'(1);
  localparam wide_t WORD_MIN = -(wide_t'(1) <<< (DW - 1));
  localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC_BITS - 1);

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [DW-1:0] measured_position_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [DW-1:0] drive_o;
  logic                 drive_clamped_o;
  logic [DW-2:0]        estimated_position_o;
  logic signed [DW-1:0] estimated_velocity_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [IDX_W-1:0]     cfg_index_i = '0;
  logic [DW-1:0]        cfg_data_i = '0;

  logic [DW-1:0] sample_queue[$];
  pid_out_t      predicted_outputs[$];
  logic [DW-1:0] reg_plan[NUM_REGS];
  logic [DW-1:0] last_sample = '0;
  logic          burst_mode = 1'b0;
  int            n_fail = 0;
  int            quiet_cycles = 0;

  wide_t setpoint_q, c_now, c_prev, c_prev2, d_prev, d_prev2, drive_lim, est_lim;
  wide_t err1, err2, raw1, raw2, drive_prev, vel_est, pos_est;

  pid_t1_controller_with_observer_unit u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .measured_position_i  (measured_position_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .drive_o              (drive_o),
    .drive_clamped_o      (drive_clamped_o),
    .estimated_position_o (estimated_position_o),
    .estimated_velocity_o (estimated_velocity_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic wide_t sat_word(input wide_t v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic wide_t round_frac(input wide_t v);
    return sat_word((v + HALF_LSB) >>> FRAC_BITS);
  endfunction

  function automatic void reset_model();
    setpoint_q = pidt1obs_pkg::RST_SETPOINT;
    c_now      = pidt1obs_pkg::RST_COEF_ERR_NOW;
    c_prev     = pidt1obs_pkg::RST_COEF_ERR_PREV;
    c_prev2    = pidt1obs_pkg::RST_COEF_ERR_PREV2;
    d_prev     = pidt1obs_pkg::RST_COEF_OUT_PREV;
    d_prev2    = pidt1obs_pkg::RST_COEF_OUT_PREV2;
    drive_lim  = pidt1obs_pkg::RST_DRIVE_LIMIT;
    est_lim    = pidt1obs_pkg::RST_ESTIMATE_LIMIT;
    err1 = '0;
    err2 = '0;
    raw1 = '0;
    raw2 = '0;
    drive_prev = '0;
    vel_est = '0;
    pos_est = '0;
  endfunction

  function automatic void store_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] data);
    case (idx)
      pidt1obs_pkg::REG_SETPOINT:       setpoint_q = $signed(data);
      pidt1obs_pkg::REG_COEF_ERR_NOW:   c_now = $signed(data);
      pidt1obs_pkg::REG_COEF_ERR_PREV:  c_prev = $signed(data);
      pidt1obs_pkg::REG_COEF_ERR_PREV2: c_prev2 = $signed(data);
      pidt1obs_pkg::REG_COEF_OUT_PREV:  d_prev = $signed(data);
      pidt1obs_pkg::REG_COEF_OUT_PREV2: d_prev2 = $signed(data);
      pidt1obs_pkg::REG_DRIVE_LIMIT:    drive_lim = $signed({1'b0, data[DW-2:0]});
      pidt1obs_pkg::REG_ESTIMATE_LIMIT: est_lim = $signed({1'b0, data[DW-2:0]});
      default: ;
    endcase
  endfunction

  function automatic void predict_control_step(input logic signed [DW-1:0] m);
    wide_t    meas, innov3, pos, err, acc, raw, drv, period;
    logic     hit;
    pid_out_t res;
    meas = m;
    period = pidt1obs_pkg::PERIOD_Q;
    innov3 = wide_t'(3) * (meas - pos_est);
    vel_est = sat_word(vel_est + round_frac((drive_prev + innov3) * period));
    pos = sat_word(pos_est + round_frac((vel_est + innov3) * period));
    if (pos > est_lim) pos = est_lim;
    if (pos < wide_t'(0)) pos = '0;
    pos_est = pos;

    err = sat_word(setpoint_q - meas);
    acc = c_now * err + c_prev * err1 + c_prev2 * err2 + d_prev * raw1 + d_prev2 * raw2;
    raw = round_frac(acc);
    err2 = err1;
    err1 = err;
    raw2 = raw1;
    raw1 = raw;

    hit = 1'b0;
    drv = raw;
    if (raw > drive_lim) begin
      drv = drive_lim;
      hit = 1'b1;
    end else if (raw < -drive_lim) begin
      drv = -drive_lim;
      hit = 1'b1;
    end
    drive_prev = drv;

    res.drive = drv[DW-1:0];
    res.clamped = hit;
    res.position = pos[DW-2:0];
    res.velocity = vel_est[DW-1:0];
    predicted_outputs.push_back(res);
  endfunction

  function automatic void check_output();
    pid_out_t want, got;
    got.drive = drive_o;
    got.clamped = drive_clamped_o;
    got.position = estimated_position_o;
    got.velocity = estimated_velocity_o;
    if (predicted_outputs.size() == 0) begin
      $error("output transfer with no sample pending");
      n_fail++;
      return;
    end
    want = predicted_outputs.pop_front();
    if (got.drive !== want.drive) begin
      $error("drive: expected %0d, actual %0d", want.drive, got.drive);
      n_fail++;
    end
    if (got.clamped !== want.clamped) begin
      $error("drive_clamped: expected %0d, actual %0d", want.clamped, got.clamped);
      n_fail++;
    end
    if (got.position !== want.position) begin
      $error("estimated_position: expected %0d, actual %0d", want.position, got.position);
      n_fail++;
    end
    if (got.velocity !== want.velocity) begin
      $error("estimated_velocity: expected %0d, actual %0d", want.velocity, got.velocity);
      n_fail++;
    end
  endfunction

  function automatic logic [DW-1:0] corner_word();
    case ($urandom_range(4))
      0: return '0;
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return {1'b1, {(DW-1){1'b0}}};
      3: return DW'(1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [DW-1:0] draw_sample();
    int unsigned   pick;
    logic [DW-1:0] s;
    pick = $urandom_range(99);
    if (pick < 35) s = last_sample + DW'($signed($urandom) >>> 22);
    else if (pick < 60) s = $signed($urandom) >>> 14;
    else if (pick < 75) s = $urandom_range(40000);
    else if (pick < 93) s = $urandom;
    else s = corner_word();
    last_sample = s;
    return s;
  endfunction

  function automatic void fill_plan(input logic [DW-1:0] sp, c0, c1, c2, d1, d2, dl, el);
    reg_plan[pidt1obs_pkg::REG_SETPOINT] = sp;
    reg_plan[pidt1obs_pkg::REG_COEF_ERR_NOW] = c0;
    reg_plan[pidt1obs_pkg::REG_COEF_ERR_PREV] = c1;
    reg_plan[pidt1obs_pkg::REG_COEF_ERR_PREV2] = c2;
    reg_plan[pidt1obs_pkg::REG_COEF_OUT_PREV] = d1;
    reg_plan[pidt1obs_pkg::REG_COEF_OUT_PREV2] = d2;
    reg_plan[pidt1obs_pkg::REG_DRIVE_LIMIT] = dl;
    reg_plan[pidt1obs_pkg::REG_ESTIMATE_LIMIT] = el;
  endfunction

  function automatic void draw_plan(input plan_e style);
    case (style)
      PLAN_DEFAULT: fill_plan(pidt1obs_pkg::RST_SETPOINT, pidt1obs_pkg::RST_COEF_ERR_NOW,
                              pidt1obs_pkg::RST_COEF_ERR_PREV,
                              pidt1obs_pkg::RST_COEF_ERR_PREV2,
                              pidt1obs_pkg::RST_COEF_OUT_PREV,
                              pidt1obs_pkg::RST_COEF_OUT_PREV2,
                              DW'(pidt1obs_pkg::RST_DRIVE_LIMIT),
                              DW'(pidt1obs_pkg::RST_ESTIMATE_LIMIT));
      PLAN_TUNED: fill_plan($signed($urandom) >>> 14, $signed($urandom) >>> 7,
                            $signed($urandom) >>> 7, $signed($urandom) >>> 7,
                            $signed($urandom) >>> 13, $signed($urandom) >>> 13,
                            $urandom_range(1 << 20), $urandom_range(1 << 18));
      PLAN_WILD: fill_plan($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      default: fill_plan(corner_word(), corner_word(), corner_word(), corner_word(),
                         corner_word(), corner_word(), corner_word(), corner_word());
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    store_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // All outputs must be back before the registers change.
  task automatic start_phase();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(negedge clk_i);
    repeat (16) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDX_W'(i), reg_plan[i]);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      measured_position_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_control_step(measured_position_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sample_queue.size() != 0 && (burst_mode || $urandom_range(99) >= 32)) begin
          in_valid_i <= 1'b1;
          measured_position_i <= sample_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_output();
      out_stall_i <= !burst_mode && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    plan_e schedule[10];
    int    n_items;
    schedule = '{PLAN_DEFAULT, PLAN_TUNED, PLAN_TUNED, PLAN_WILD, PLAN_TUNED,
                 PLAN_CORNER, PLAN_TUNED, PLAN_DEFAULT, PLAN_TUNED, PLAN_WILD};
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: zero error, extremes and error overflow.
    sample_queue = '{32'sd0, 32'sd9175, 32'sd20119, 32'sd20120, -32'sd1, 32'sd1,
                     32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'sd0,
                     32'sd65536, -32'sd65536};

    // Unity gain on the error: the output sits exactly on and just past the limit.
    fill_plan('0, 32'sd65536, '0, '0, '0, '0, 32'd1000, 32'h7FFFFFFF);
    start_phase();
    sample_queue = '{-32'sd1000, 32'sd1000, -32'sd1001, 32'sd1001, 32'h80000001,
                     32'h80000000};

    fill_plan(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, '0);
    start_phase();
    sample_queue = '{32'h80000000, 32'h7FFFFFFF, 32'sd0};

    fill_plan(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, '0, 32'h7FFFFFFF);
    start_phase();
    sample_queue = '{32'h7FFFFFFF, 32'h80000000, 32'sd0, 32'sd5};

    foreach (schedule[p]) begin
      draw_plan(schedule[p]);
      start_phase();
      burst_mode = (p == 4);
      n_items = $urandom_range(110, 140);
      for (int i = 0; i < n_items; i++) sample_queue.push_back(draw_sample());
    end

    @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(negedge clk_i);
    burst_mode = 1'b0;
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
